// ----- rtl/core/cfbc_pkg.sv -----
// Package for the command frame builder: command codes, register indexes,
// descriptor types and the CRC-8, tag and argument-count lookup functions.
// No dependencies.
package cfbc_pkg;

  localparam int unsigned FuncW          = 4;
  localparam int unsigned WideArgW       = 16;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned ArgSlots       = 6;
  localparam int unsigned ArgCntW        = 3;
  localparam int unsigned CfgIdxW        = 8;
  localparam int unsigned PayloadBytesDef = 8;
  localparam int unsigned QueueDepthDef  = 2;

  localparam logic [ByteW-1:0] CrcPoly = 8'h8C;

  typedef enum logic [FuncW-1:0] {
    CMD_FOG        = 4'd0,
    CMD_LED        = 4'd1,
    CMD_RGB        = 4'd2,
    CMD_FOG_STATUS = 4'd3,
    CMD_LED_STATUS = 4'd4,
    CMD_SET_TIME   = 4'd5,
    CMD_RING       = 4'd6,
    CMD_MODE       = 4'd7,
    CMD_SIZE       = 4'd8
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_MARKER = 8'd0,
    REG_STOP_MARKER  = 8'd1
  } cfg_reg_e;

  // One classified command, payload slots already zeroed where unused
  typedef struct packed {
    logic [ByteW-1:0]                tag;
    logic [ArgSlots-1:0][ByteW-1:0]  args;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } q_req_t;

  typedef struct packed {
    logic active;
    logic frame_done;
  } back_status_t;

  function automatic logic [ByteW-1:0] cmd_tag(input logic [FuncW-1:0] func);
    logic [ByteW-1:0] tag;
    unique case (func)
      CMD_FOG:        tag = 8'hF1;
      CMD_LED:        tag = 8'hF6;
      CMD_RGB:        tag = 8'hF7;
      CMD_FOG_STATUS: tag = 8'hF5;
      CMD_LED_STATUS: tag = 8'hF9;
      CMD_SET_TIME:   tag = 8'hE1;
      CMD_RING:       tag = 8'hE2;
      CMD_MODE:       tag = 8'hF8;
      CMD_SIZE:       tag = 8'hF3;
      default:        tag = '0;
    endcase
    return tag;
  endfunction

  function automatic logic [ArgCntW-1:0] cmd_arg_count(input logic [FuncW-1:0] func);
    logic [ArgCntW-1:0] cnt;
    unique case (func)
      CMD_FOG, CMD_LED, CMD_RING, CMD_MODE, CMD_SIZE: cnt = 3'd1;
      CMD_RGB:                                        cnt = 3'd3;
      CMD_SET_TIME:                                   cnt = 3'd6;
      default:                                        cnt = 3'd0;
    endcase
    return cnt;
  endfunction

  // Dallas/Maxim CRC-8, reflected, one byte folded in
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < ByteW; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/cfbc_if.sv -----
// Channel interfaces of the command frame builder: command, frame byte and
// configuration write. Depends on cfbc_pkg.
interface cfbc_cmd_if;
  import cfbc_pkg::*;
  logic                valid;
  logic                ready;
  logic [FuncW-1:0]    func;
  logic [WideArgW-1:0] first_arg;
  logic [ByteW-1:0]    second_arg;
  logic [ByteW-1:0]    third_arg;
  logic [ByteW-1:0]    fourth_arg;
  logic [ByteW-1:0]    fifth_arg;
  logic [ByteW-1:0]    sixth_arg;

  modport source (output valid, func, first_arg, second_arg, third_arg, fourth_arg,
                  fifth_arg, sixth_arg, input ready);
  modport sink   (input valid, func, first_arg, second_arg, third_arg, fourth_arg,
                  fifth_arg, sixth_arg, output ready);
endinterface

interface cfbc_frame_if;
  import cfbc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] frame_byte;
  logic             frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface cfbc_cfg_if;
  import cfbc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/cfbc_front.sv -----
// Front end: accepts command beats, drops unknown selectors and builds the
// frame descriptor (tag and zero-filled payload slots). Depends on cfbc_pkg.
module cfbc_front #(
  parameter int unsigned PAYLOAD_BYTES = cfbc_pkg::PayloadBytesDef
) (
  cfbc_cmd_if.sink          cmd_i,
  output cfbc_pkg::q_req_t  push_o,
  input  logic              push_ready_i
);
  import cfbc_pkg::*;

  logic                            legal;
  logic [ArgCntW-1:0]              nargs;
  logic [ArgSlots-1:0][ByteW-1:0]  raw_args;

  assign legal = (cmd_i.func <= CMD_SIZE);
  assign nargs = cmd_arg_count(cmd_i.func);

  assign raw_args[0] = cmd_i.first_arg[ByteW-1:0];
  assign raw_args[1] = cmd_i.second_arg;
  assign raw_args[2] = cmd_i.third_arg;
  assign raw_args[3] = cmd_i.fourth_arg;
  assign raw_args[4] = cmd_i.fifth_arg;
  assign raw_args[5] = cmd_i.sixth_arg;

  always_comb begin
    push_o.valid    = cmd_i.valid && legal;
    push_o.desc.tag = cmd_tag(cmd_i.func);
    for (int i = 0; i < ArgSlots; i++) begin
      // zero slots the command leaves unused or the payload cannot hold
      if ((ArgCntW'(i) < nargs) && (i < PAYLOAD_BYTES)) begin
        push_o.desc.args[i] = raw_args[i];
      end else begin
        push_o.desc.args[i] = '0;
      end
    end
  end

  // drop unknown selectors at once
  assign cmd_i.ready = !legal || push_ready_i;

endmodule

// ----- rtl/core/cfbc_queue.sv -----
// Short descriptor queue between front and back end.
// Depends on cfbc_pkg.
module cfbc_queue #(
  parameter int unsigned DEPTH = cfbc_pkg::QueueDepthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfbc_pkg::q_req_t        push_i,
  output logic                    push_ready_o,
  output logic                    pop_valid_o,
  output cfbc_pkg::desc_t         pop_desc_o,
  input  logic                    pop_ready_i
);
  import cfbc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  desc_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_desc_o   = mem_q[rd_ptr_q];
  assign push         = push_i.valid && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.desc;
    end
  end

endmodule

// ----- rtl/core/cfbc_back.sv -----
// Back end: serialises one descriptor into a frame, one byte a cycle while
// frame_o is ready, with running CRC-8 and a registered output stage. Depends on cfbc_pkg.
module cfbc_back #(
  parameter int unsigned PAYLOAD_BYTES = cfbc_pkg::PayloadBytesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pop_valid_i,
  input  cfbc_pkg::desc_t            pop_desc_i,
  output logic                       pop_ready_o,
  input  logic [cfbc_pkg::ByteW-1:0] start_marker_i,
  input  logic [cfbc_pkg::ByteW-1:0] stop_marker_i,
  output cfbc_pkg::back_status_t     status_o,
  cfbc_frame_if.source               frame_o
);
  import cfbc_pkg::*;

  localparam int unsigned FrameLen = PAYLOAD_BYTES + 4;
  localparam int unsigned PosW     = $clog2(FrameLen);

  logic             active_q, active_d;
  desc_t            desc_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] crc_q, crc_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q;
  logic             out_end_q;

  logic             load, last, pop;
  logic [PosW-1:0]  slot;
  logic [ByteW-1:0] cur_byte;

  assign load = active_q && (!out_valid_q || frame_o.ready);
  assign last = (pos_q == PosW'(FrameLen - 1));
  assign slot = pos_q - PosW'(2);
  assign pop_ready_o = !active_q || (load && last);
  assign pop  = pop_valid_i && pop_ready_o;

  always_comb begin
    if (pos_q == '0) begin
      cur_byte = start_marker_i;
    end else if (pos_q == PosW'(1)) begin
      cur_byte = desc_q.tag;
    end else if (pos_q == PosW'(FrameLen - 2)) begin
      cur_byte = stop_marker_i;
    end else if (last) begin
      cur_byte = crc_q;
    end else if (slot < PosW'(ArgSlots)) begin
      cur_byte = desc_q.args[slot[ArgCntW-1:0]];
    end else begin
      cur_byte = '0;
    end
  end

  always_comb begin
    active_d    = active_q;
    pos_d       = pos_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    if (load) begin
      pos_d       = last ? '0 : pos_q + 1'b1;
      // restart the check at the start byte
      crc_d       = crc8_byte((pos_q == '0) ? '0 : crc_q, cur_byte);
      out_valid_d = 1'b1;
    end else if (frame_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pop) begin
      active_d = 1'b1;
      pos_d    = '0;
    end else if (load && last) begin
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pos_q       <= '0;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      desc_q <= pop_desc_i;
    end
    if (load) begin
      out_byte_q <= cur_byte;
      out_end_q  <= last;
    end
  end

  assign frame_o.valid      = out_valid_q;
  assign frame_o.frame_byte = out_byte_q;
  assign frame_o.frame_end  = out_end_q;

  assign status_o.active     = active_q;
  assign status_o.frame_done = load && last;

endmodule

// ----- rtl/core/command_frame_builder_crc8_top.sv -----
// Top level of the command frame builder with CRC-8: marker registers,
// front end, descriptor queue and serialising back end.
// Depends on cfbc_pkg, cfbc_if, cfbc_front, cfbc_queue, cfbc_back.
//
//   channel   dir  payload                                   beat
//   cmd_i     in   func, first_arg .. sixth_arg              one command
//   frame_o   out  frame_byte, frame_end                     one frame byte
//   cfg_i     in   index, data                               one register write
//
// A frame is PAYLOAD_BYTES + 4 beats (12 by default), one beat a cycle when
// the sink keeps ready high; the single byte-wide output register sets the rate.
// A command reaches frame_o through the queue, the serialiser and the output register.
// The queue holds QUEUE_DEPTH commands, so the front keeps accepting while a
// frame drains; an unknown selector is taken and dropped at once.
// Reset clears markers, queue and serialiser; a stall on frame_o holds the byte.
module command_frame_builder_crc8_top #(
  parameter int unsigned PAYLOAD_BYTES = cfbc_pkg::PayloadBytesDef,
  parameter int unsigned QUEUE_DEPTH   = cfbc_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cfbc_cmd_if.sink      cmd_i,
  cfbc_frame_if.source  frame_o,
  cfbc_cfg_if.sink      cfg_i
);
  import cfbc_pkg::*;

  logic [ByteW-1:0] start_marker_q;
  logic [ByteW-1:0] stop_marker_q;
  q_req_t           q_push;
  logic             q_push_ready;
  logic             q_pop_valid;
  desc_t            q_pop_desc;
  logic             q_pop_ready;
  back_status_t     back_status;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= '0;
      stop_marker_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_START_MARKER: start_marker_q <= cfg_i.data;
        REG_STOP_MARKER:  stop_marker_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  cfbc_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .cmd_i        (cmd_i),
    .push_o       (q_push),
    .push_ready_i (q_push_ready)
  );

  cfbc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_ready_o (q_push_ready),
    .pop_valid_o  (q_pop_valid),
    .pop_desc_o   (q_pop_desc),
    .pop_ready_i  (q_pop_ready)
  );

  cfbc_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (q_pop_valid),
    .pop_desc_i     (q_pop_desc),
    .pop_ready_o    (q_pop_ready),
    .start_marker_i (start_marker_q),
    .stop_marker_i  (stop_marker_q),
    .status_o       (back_status),
    .frame_o        (frame_o)
  );

  // only known selectors reach the queue
  a_push_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push.valid && q_push_ready) |-> (cmd_i.func <= CMD_SIZE))
    else $error("unknown selector pushed into queue");

  // an idle serialiser picks up a waiting command in the next cycle
  a_pickup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_valid && !back_status.active) |=> back_status.active)
    else $error("queued command not picked up");

  // the check byte follows the last serialiser step
  a_end_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.frame_done |=> (frame_o.valid && frame_o.frame_end))
    else $error("frame end not flagged after last byte");

  // a frame never ends two beats in a row
  a_no_double_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_o.valid && frame_o.ready && frame_o.frame_end) |=> !frame_o.frame_end || !frame_o.valid)
    else $error("frame end repeated");

endmodule
